### rtl/bmph_pkg.sv
package bmph_pkg;

  // display geometry
  localparam int unsigned WIDTH  = 32;
  localparam int unsigned HEIGHT = 32;

  // field widths
  localparam int unsigned COL_W    = 5;
  localparam int unsigned NUM_COLS = 1 << COL_W;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned BAR_W    = 8;
  localparam int unsigned PEAK_W   = 6;
  localparam int unsigned WGT_W    = 9;
  localparam int unsigned HOLD_W   = 9;
  localparam int unsigned PERIOD_W = 8;

  // target row runs 0..HEIGHT, stored peak 0..HEIGHT+1
  localparam int unsigned TGT_W  = $clog2(HEIGHT + 2);
  localparam int unsigned PSTO_W = $clog2(HEIGHT + 2);

  // level / 20 as a reciprocal multiply, exact for every 16-bit level
  localparam int unsigned DIV_SHIFT = LEVEL_W + 5;
  localparam int unsigned DIV_MULT  = ((1 << DIV_SHIFT) + 19) / 20;
  localparam int unsigned DIV_MW    = $clog2(DIV_MULT + 1);
  localparam int unsigned DROP_W    = LEVEL_W + DIV_MW - DIV_SHIFT;

  // smoothing sum: two products, one bit of carry
  localparam int unsigned SUM_W = WGT_W + BAR_W + 1;

  // stream payload widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // configuration port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [2:0] REG_PREV_WGT    = 3'd0;
  localparam logic [2:0] REG_TGT_WGT     = 3'd1;
  localparam logic [2:0] REG_BOTTOM_SHOW = 3'd2;
  localparam logic [2:0] REG_PEAK_EN     = 3'd3;
  localparam logic [2:0] REG_HOLD_PERIOD = 3'd4;

  localparam logic [WGT_W-1:0]    PREV_WGT_RST    = 9'd128;
  localparam logic [WGT_W-1:0]    TGT_WGT_RST     = 9'd128;
  localparam logic                BOTTOM_SHOW_RST = 1'b1;
  localparam logic                PEAK_EN_RST     = 1'b0;
  localparam logic [PERIOD_W-1:0] HOLD_PERIOD_RST = 8'd15;

  typedef struct packed {
    logic [WGT_W-1:0]    prev_wgt;
    logic [WGT_W-1:0]    tgt_wgt;
    logic                bottom_shown;
    logic                peak_en;
    logic [PERIOD_W-1:0] hold_period;
  } cfg_t;

endpackage

### rtl/bar_meter_peak_hold.sv
// Bar graph meter with peak hold.
// Input stream: one transfer per column update, tdata = {level, column}.
// Output stream: one transfer per input, tdata = {peak_visible, peak_row,
// bar_top, out_column}. Results leave in input order.
// Throughput: one item per cycle while the output is not stalled. The pipe
// is input register, target stage (level/20 by reciprocal multiply), then
// the column update stage which reads and writes the per-column bar/peak/hold
// registers in the same cycle, so back-to-back items on the same column see
// each other's updates.
// Stalls: each stage holds when the next is full and not moving; the input
// keeps accepting while bubbles remain in the pipe and a result waits.
// Reset: clears the pipe, the per-column state (all rows and counters zero)
// and sets the registers to their defaults. Config is written over APB,
// registers at byte addresses 0,4,8,12,16; pready is always high.
module bar_meter_peak_hold (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] column, [20:5] level, [23:21] zero
  input  logic [bmph_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [4:0] out_column, [12:5] bar_top, [18:13] peak_row, [19] peak_visible,
  // [23:20] zero
  output logic [bmph_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmph_pkg::APB_AW-1:0]      paddr,
  input  logic [bmph_pkg::APB_DW-1:0]      pwdata,
  output logic [bmph_pkg::APB_DW-1:0]      prdata,
  output logic                           pready
);
  import bmph_pkg::*;

  // ---------------- configuration ----------------
  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prev_wgt     <= PREV_WGT_RST;
      cfg_q.tgt_wgt      <= TGT_WGT_RST;
      cfg_q.bottom_shown <= BOTTOM_SHOW_RST;
      cfg_q.peak_en      <= PEAK_EN_RST;
      cfg_q.hold_period  <= HOLD_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PREV_WGT:    cfg_q.prev_wgt     <= pwdata[WGT_W-1:0];
        REG_TGT_WGT:     cfg_q.tgt_wgt      <= pwdata[WGT_W-1:0];
        REG_BOTTOM_SHOW: cfg_q.bottom_shown <= pwdata[0];
        REG_PEAK_EN:     cfg_q.peak_en      <= pwdata[0];
        REG_HOLD_PERIOD: cfg_q.hold_period  <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PREV_WGT:    prdata = APB_DW'(cfg_q.prev_wgt);
      REG_TGT_WGT:     prdata = APB_DW'(cfg_q.tgt_wgt);
      REG_BOTTOM_SHOW: prdata = APB_DW'(cfg_q.bottom_shown);
      REG_PEAK_EN:     prdata = APB_DW'(cfg_q.peak_en);
      REG_HOLD_PERIOD: prdata = APB_DW'(cfg_q.hold_period);
      default:         prdata = '0;
    endcase
  end

  // ---------------- pipe control ----------------
  logic v1_q, v2_q, vo_q;
  logic rdy1, rdy2, rdyo;

  assign rdyo          = ~vo_q | m_axis_tready;
  assign rdy2          = ~v2_q | rdyo;
  assign rdy1          = ~v1_q | rdy2;
  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdyo) vo_q <= v2_q;
    end
  end

  // ---------------- input register ----------------
  logic [COL_W-1:0]   col1_q;
  logic [LEVEL_W-1:0] level1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      col1_q   <= s_axis_tdata[COL_W-1:0];
      level1_q <= s_axis_tdata[COL_W+LEVEL_W-1:COL_W];
    end
  end

  // ---------------- target row ----------------
  logic [LEVEL_W+DIV_MW-1:0] div_prod;
  logic [DROP_W-1:0]         drop;
  logic [TGT_W-1:0]          tgt_d, tgt2_q;
  logic [COL_W-1:0]          col2_q;

  assign div_prod = (LEVEL_W+DIV_MW)'(level1_q) * (LEVEL_W+DIV_MW)'(DIV_MULT);
  assign drop     = div_prod[LEVEL_W+DIV_MW-1:DIV_SHIFT];

  always_comb begin
    if (32'(drop) >= HEIGHT) tgt_d = '0;
    else                     tgt_d = TGT_W'(HEIGHT - 32'(drop));
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      col2_q <= col1_q;
      tgt2_q <= tgt_d;
    end
  end

  // ---------------- column update ----------------
  logic [BAR_W-1:0]  bar_sto_q  [NUM_COLS];
  logic [PSTO_W-1:0] peak_sto_q [NUM_COLS];
  logic [HOLD_W-1:0] hold_sto_q [NUM_COLS];

  logic              col_ok;
  logic              upd;
  logic [BAR_W-1:0]  bar_old;
  logic [SUM_W-1:0]  wsum;
  logic [SUM_W-8:0]  bar_sh;
  logic [BAR_W-1:0]  bar_d;
  logic [PSTO_W-1:0] peak_old, peak_c, peak_d;
  logic [HOLD_W-1:0] hold_old, hold_d;
  logic              vis_d;

  assign col_ok   = 32'(col2_q) < WIDTH;
  assign upd      = rdyo & v2_q & col_ok;
  assign bar_old  = bar_sto_q[col2_q];
  assign peak_old = peak_sto_q[col2_q];
  assign hold_old = hold_sto_q[col2_q];

  assign wsum = SUM_W'(cfg_q.prev_wgt) * SUM_W'(bar_old) +
                SUM_W'(cfg_q.tgt_wgt) * SUM_W'(tgt2_q);
  // floor(/256), plus one row when the bottom row is hidden
  assign bar_sh = (SUM_W-7)'(wsum[SUM_W-1:8]) +
                  {{(SUM_W-8){1'b0}}, ~cfg_q.bottom_shown};

  always_comb begin
    bar_d = (32'(bar_sh) > 255) ? BAR_W'(255) : bar_sh[BAR_W-1:0];

    peak_c = peak_old;
    if (PSTO_W'(tgt2_q) < peak_c) peak_c = PSTO_W'(tgt2_q);
    if (32'(peak_c) > HEIGHT)     peak_c = PSTO_W'(HEIGHT);

    // counter ran out: let the peak fall one row and reload
    if (hold_old[HOLD_W-1]) begin
      peak_d = peak_c + PSTO_W'(1);
      hold_d = HOLD_W'(cfg_q.hold_period);
    end else begin
      peak_d = peak_c;
      hold_d = hold_old - HOLD_W'(1);
    end

    vis_d = cfg_q.peak_en & (32'(peak_d) != HEIGHT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COLS; i++) begin
        bar_sto_q[i]  <= '0;
        peak_sto_q[i] <= '0;
        hold_sto_q[i] <= '0;
      end
    end else if (upd) begin
      bar_sto_q[col2_q]  <= bar_d;
      peak_sto_q[col2_q] <= peak_d;
      hold_sto_q[col2_q] <= hold_d;
    end
  end

  // ---------------- result register ----------------
  logic [COL_W-1:0]  col_o_q;
  logic [BAR_W-1:0]  bar_o_q;
  logic [PEAK_W-1:0] peak_o_q;
  logic              vis_o_q;

  always_ff @(posedge clk_i) begin
    if (rdyo && v2_q) begin
      col_o_q  <= col2_q;
      bar_o_q  <= col_ok ? bar_d : '0;
      peak_o_q <= col_ok ? PEAK_W'(peak_d) : '0;
      vis_o_q  <= col_ok & vis_d;
    end
  end

  assign m_axis_tdata = {
    (OUT_TDATA_W - COL_W - BAR_W - PEAK_W - 1)'(0),
    vis_o_q, peak_o_q, bar_o_q, col_o_q
  };

`ifndef SYNTHESIS
  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> (32'(peak_o_q) <= HEIGHT + 1))
    else $error("peak row beyond one below the display");

  a_vis_needs_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && vis_o_q) |-> cfg_q.peak_en)
    else $error("peak visible while peak display is off");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdyo) |=> vo_q)
    else $error("column update lost on its way to the result register");
`endif

endmodule
